// File: rtl/core/keyboard_link_protocol_engine_macros.svh
// Assertion macros shared by the keyboard link RTL.
// Each macro checks one implication on the rising clock, disabled during reset.
`ifndef KEYBOARD_LINK_PROTOCOL_ENGINE_MACROS_SVH
`define KEYBOARD_LINK_PROTOCOL_ENGINE_MACROS_SVH

// same-cycle implication
`define KBL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kbl: same-cycle check failed");

// next-cycle implication
`define KBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kbl: next-cycle check failed");

`endif

// File: rtl/core/kbl_pkg.sv
// Shared constants and types of the keyboard link protocol engine.
// No dependencies; used by kbl_mouse_acc and the top level.
`default_nettype none

package kbl_pkg;

    localparam int ACC_WIDTH = 16;
    localparam int DELTA_W   = 12;
    localparam int SUM_W     = ((ACC_WIDTH > DELTA_W) ? ACC_WIDTH : DELTA_W) + 1;
    localparam int MOUSE_W   = 7;
    localparam int KB_ID_W   = 6;

    localparam logic [KB_ID_W-1:0] KB_ID_RESET = 6'd1;

    // item kinds
    localparam logic [1:0] OP_HOST  = 2'd0;
    localparam logic [1:0] OP_KEY   = 2'd1;
    localparam logic [1:0] OP_MOUSE = 2'd2;

    // link byte codes
    localparam logic [7:0] C_HRST = 8'hFF;
    localparam logic [7:0] C_RAK1 = 8'hFE;
    localparam logic [7:0] C_RAK2 = 8'hFD;
    localparam logic [7:0] C_RQID = 8'h20;
    localparam logic [7:0] C_PRST = 8'h21;
    localparam logic [7:0] C_RQMP = 8'h22;
    localparam logic [7:0] C_BACK = 8'h3F;
    localparam logic [7:0] C_PDAT = 8'hE0;
    localparam logic [3:0] C_RQPD_HI = 4'h4;
    localparam logic [1:0] C_KBID_HI = 2'b10;
    localparam logic [3:0] C_KDDA_HI = 4'hC;
    localparam logic [3:0] C_KUDA_HI = 4'hD;
    // NACK/SACK/MACK/SMAK share 0x30-0x33: bit 0 scan, bit 1 mouse
    localparam logic [5:0] C_MODE_HI = 6'b001100;
    localparam logic [7:0] C_LED_MAX = 8'd7;

    typedef struct packed {
        logic add;
        logic clear;
    } t_mouse_ctl;

endpackage

`default_nettype wire

// File: rtl/core/kbl_mouse_acc.sv
// Saturating mouse accumulators with the 7-bit clamped report values.
// Depends on kbl_pkg.
`default_nettype none

module kbl_mouse_acc (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire kbl_pkg::t_mouse_ctl                 i_ctl,
    input  wire logic signed [kbl_pkg::DELTA_W-1:0]  i_delta_x,
    input  wire logic signed [kbl_pkg::DELTA_W-1:0]  i_delta_y,
    output logic             [kbl_pkg::MOUSE_W-1:0]  o_mouse_x,
    output logic             [kbl_pkg::MOUSE_W-1:0]  o_mouse_y
);

    logic [kbl_pkg::ACC_WIDTH-1:0] r_acc_x;
    logic [kbl_pkg::ACC_WIDTH-1:0] r_acc_y;
    logic [kbl_pkg::ACC_WIDTH-1:0] sum_x;
    logic [kbl_pkg::ACC_WIDTH-1:0] sum_y;

    function automatic logic [kbl_pkg::ACC_WIDTH-1:0] sat_add(
        input logic [kbl_pkg::ACC_WIDTH-1:0] acc,
        input logic [kbl_pkg::DELTA_W-1:0]   d
    );
        logic [kbl_pkg::SUM_W-1:0]                     s;
        logic [kbl_pkg::SUM_W-kbl_pkg::ACC_WIDTH:0]    hb;
        s = {{(kbl_pkg::SUM_W-kbl_pkg::ACC_WIDTH){acc[kbl_pkg::ACC_WIDTH-1]}}, acc}
          + {{(kbl_pkg::SUM_W-kbl_pkg::DELTA_W){d[kbl_pkg::DELTA_W-1]}}, d};
        hb = s[kbl_pkg::SUM_W-1:kbl_pkg::ACC_WIDTH-1];
        if ((&hb) || !(|hb)) begin
            sat_add = s[kbl_pkg::ACC_WIDTH-1:0];
        end else if (s[kbl_pkg::SUM_W-1]) begin
            sat_add = {1'b1, {(kbl_pkg::ACC_WIDTH-1){1'b0}}};
        end else begin
            sat_add = {1'b0, {(kbl_pkg::ACC_WIDTH-1){1'b1}}};
        end
    endfunction

    // clamp to -64..63 and keep the low seven bits
    function automatic logic [kbl_pkg::MOUSE_W-1:0] clamp7(
        input logic [kbl_pkg::ACC_WIDTH-1:0] v
    );
        logic [kbl_pkg::ACC_WIDTH-kbl_pkg::MOUSE_W:0] hb;
        hb = v[kbl_pkg::ACC_WIDTH-1:kbl_pkg::MOUSE_W-1];
        if ((&hb) || !(|hb)) begin
            clamp7 = v[kbl_pkg::MOUSE_W-1:0];
        end else if (v[kbl_pkg::ACC_WIDTH-1]) begin
            clamp7 = {1'b1, {(kbl_pkg::MOUSE_W-1){1'b0}}};
        end else begin
            clamp7 = {1'b0, {(kbl_pkg::MOUSE_W-1){1'b1}}};
        end
    endfunction

    always_comb begin
        sum_x = i_ctl.add ? sat_add(r_acc_x, i_delta_x) : r_acc_x;
        sum_y = i_ctl.add ? sat_add(r_acc_y, i_delta_y) : r_acc_y;
    end

    // report reflects this item's movement before the clear
    assign o_mouse_x = clamp7(sum_x);
    assign o_mouse_y = clamp7(sum_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else if (i_ctl.clear) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else begin
            r_acc_x <= sum_x;
            r_acc_y <= sum_y;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/keyboard_link_protocol_engine.sv
// Keyboard link protocol engine: top level with protocol decode and handshake.
// Depends on kbl_pkg, kbl_mouse_acc and keyboard_link_protocol_engine_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: a host byte, a
//   key event or a mouse movement. Output channel (o_out_valid / i_out_stall)
//   carries exactly one result per item: an optional byte to the host plus the
//   LED state. The configuration channel (i_cfg_valid / o_cfg_ready) writes the
//   6-bit keyboard ID; it is always ready and is meant to be used while idle.
//   An item sits in an input register, then the decode logic writes the
//   protocol state, the mouse accumulators and the output register.
//   Throughput: one item per cycle while the receiver does not stall, limited
//   by the single decode stage that updates the protocol state.
//   Reset (synchronous, active low) puts the link in the pre-reset state with
//   LEDs, modes and accumulators cleared, and the keyboard ID at 1.
//   When the receiver stalls, the result holds in the output register; one
//   more item is taken into the input register, then o_in_stall rises.
`default_nettype none

`include "keyboard_link_protocol_engine_macros.svh"

module keyboard_link_protocol_engine (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic        [kbl_pkg::KB_ID_W-1:0]  i_cfg_data,
    // input items
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic        [1:0]                   i_op,
    input  wire logic        [7:0]                   i_rx_byte,
    input  wire logic        [7:0]                   i_key_code,
    input  wire logic                                i_key_pressed,
    input  wire logic signed [kbl_pkg::DELTA_W-1:0]  i_delta_x,
    input  wire logic signed [kbl_pkg::DELTA_W-1:0]  i_delta_y,
    // results
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_tx_valid,
    output logic             [7:0]                   o_tx_byte,
    output logic                                     o_leds_changed,
    output logic             [2:0]                   o_led_state
);

    typedef enum logic [2:0] {
        ST_PRE    = 3'd0,
        ST_HRST   = 3'd1,
        ST_RAK1   = 3'd2,
        ST_INIT   = 3'd3,
        ST_FIRST  = 3'd4,
        ST_SECOND = 3'd5
    } t_proto_st;

    // input register
    logic                                r_in_valid;
    logic        [1:0]                   r_in_op;
    logic        [7:0]                   r_in_rx;
    logic        [7:0]                   r_in_code;
    logic                                r_in_pressed;
    logic signed [kbl_pkg::DELTA_W-1:0]  r_in_dx;
    logic signed [kbl_pkg::DELTA_W-1:0]  r_in_dy;

    // protocol state
    t_proto_st                       r_state, n_state;
    logic [2:0]                      r_led, n_led;
    logic                            r_scan, n_scan;
    logic                            r_mrep, n_mrep;
    logic [7:0]                      r_pend, n_pend;
    logic [kbl_pkg::KB_ID_W-1:0]     r_kb_id;

    // output register
    logic                            r_out_valid;
    logic                            r_tx_valid, n_tx_valid;
    logic [7:0]                      r_tx_byte, n_tx_byte;
    logic                            r_changed, n_changed;

    logic                            in_xfer;
    logic                            advance;
    logic                            fire;
    logic                            host_ok;
    logic                            enter_first;
    kbl_pkg::t_mouse_ctl             mouse_ctl;
    logic [kbl_pkg::MOUSE_W-1:0]     mouse_x;
    logic [kbl_pkg::MOUSE_W-1:0]     mouse_y;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer || o_in_stall;
        end
        if (in_xfer) begin
            r_in_op      <= i_op;
            r_in_rx      <= i_rx_byte;
            r_in_code    <= i_key_code;
            r_in_pressed <= i_key_pressed;
            r_in_dx      <= i_delta_x;
            r_in_dy      <= i_delta_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kb_id <= kbl_pkg::KB_ID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_kb_id <= i_cfg_data;
        end
    end

    kbl_mouse_acc u_mouse_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mouse_ctl),
        .i_delta_x (r_in_dx),
        .i_delta_y (r_in_dy),
        .o_mouse_x (mouse_x),
        .o_mouse_y (mouse_y)
    );

    always_comb begin
        n_state    = r_state;
        n_led      = r_led;
        n_scan     = r_scan;
        n_mrep     = r_mrep;
        n_pend     = r_pend;
        n_tx_valid = 1'b0;
        n_tx_byte  = 8'h00;
        n_changed  = 1'b0;
        host_ok    = 1'b0;
        mouse_ctl  = '0;
        if (fire) begin
            case (r_in_op)
                kbl_pkg::OP_HOST: begin
                    if (r_in_rx == kbl_pkg::C_HRST) begin
                        n_state    = ST_HRST;
                        n_tx_valid = 1'b1;
                        n_tx_byte  = kbl_pkg::C_HRST;
                        host_ok    = 1'b1;
                    end else begin
                        case (r_state)
                            ST_HRST: begin
                                if (r_in_rx == kbl_pkg::C_RAK1) begin
                                    n_state    = ST_RAK1;
                                    n_tx_valid = 1'b1;
                                    n_tx_byte  = kbl_pkg::C_RAK1;
                                    host_ok    = 1'b1;
                                end
                            end
                            ST_RAK1: begin
                                if (r_in_rx == kbl_pkg::C_RAK2) begin
                                    n_state    = ST_INIT;
                                    n_tx_valid = 1'b1;
                                    n_tx_byte  = kbl_pkg::C_RAK2;
                                    host_ok    = 1'b1;
                                end
                            end
                            ST_INIT: begin
                                host_ok = 1'b1;
                                if (r_in_rx == kbl_pkg::C_PRST) begin
                                    n_state    = ST_PRE;
                                    n_tx_valid = 1'b1;
                                    n_tx_byte  = kbl_pkg::C_HRST;
                                end else if (r_in_rx == kbl_pkg::C_RQID) begin
                                    n_tx_valid = 1'b1;
                                    n_tx_byte  = {kbl_pkg::C_KBID_HI, r_kb_id};
                                end else if (r_in_rx == kbl_pkg::C_RQMP) begin
                                    mouse_ctl.clear = 1'b1;
                                    n_pend     = {1'b0, mouse_y};
                                    n_state    = ST_FIRST;
                                    n_tx_valid = 1'b1;
                                    n_tx_byte  = {1'b0, mouse_x};
                                end else if (r_in_rx <= kbl_pkg::C_LED_MAX) begin
                                    n_led     = r_in_rx[2:0];
                                    n_changed = (r_in_rx[2:0] != r_led);
                                end else if (r_in_rx[7:4] == kbl_pkg::C_RQPD_HI) begin
                                    n_tx_valid = 1'b1;
                                    n_tx_byte  = kbl_pkg::C_PDAT;
                                end else if (r_in_rx[7:2] == kbl_pkg::C_MODE_HI) begin
                                    n_scan = r_in_rx[0];
                                    n_mrep = r_in_rx[1];
                                end else begin
                                    host_ok = 1'b0;
                                end
                            end
                            ST_FIRST: begin
                                if (r_in_rx == kbl_pkg::C_BACK) begin
                                    n_state    = ST_SECOND;
                                    n_tx_valid = 1'b1;
                                    n_tx_byte  = r_pend;
                                    host_ok    = 1'b1;
                                end
                            end
                            ST_SECOND: begin
                                if (r_in_rx[7:2] == kbl_pkg::C_MODE_HI) begin
                                    n_scan  = r_in_rx[0];
                                    n_mrep  = r_in_rx[1];
                                    n_state = ST_INIT;
                                    host_ok = 1'b1;
                                end
                            end
                            default: begin
                                host_ok = 1'b0;
                            end
                        endcase
                        // protocol error: answer HRST, drop back to pre-reset
                        if (!host_ok) begin
                            n_state    = ST_PRE;
                            n_tx_valid = 1'b1;
                            n_tx_byte  = kbl_pkg::C_HRST;
                        end
                    end
                end
                kbl_pkg::OP_KEY: begin
                    if (r_scan && (r_state == ST_INIT)) begin
                        n_state    = ST_FIRST;
                        n_tx_valid = 1'b1;
                        if (r_in_pressed) begin
                            n_pend    = {kbl_pkg::C_KDDA_HI, r_in_code[3:0]};
                            n_tx_byte = {kbl_pkg::C_KDDA_HI, r_in_code[7:4]};
                        end else begin
                            n_pend    = {kbl_pkg::C_KUDA_HI, r_in_code[3:0]};
                            n_tx_byte = {kbl_pkg::C_KUDA_HI, r_in_code[7:4]};
                        end
                    end
                end
                kbl_pkg::OP_MOUSE: begin
                    mouse_ctl.add = 1'b1;
                    if (r_mrep && (r_state == ST_INIT)) begin
                        mouse_ctl.clear = 1'b1;
                        n_pend     = {1'b0, mouse_y};
                        n_state    = ST_FIRST;
                        n_tx_valid = 1'b1;
                        n_tx_byte  = {1'b0, mouse_x};
                    end
                end
                default: begin
                    // unused op: nothing sent, state held
                    n_state = r_state;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_PRE;
            r_led       <= 3'd0;
            r_scan      <= 1'b0;
            r_mrep      <= 1'b0;
            r_pend      <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_led       <= n_led;
            r_scan      <= n_scan;
            r_mrep      <= n_mrep;
            r_pend      <= n_pend;
            r_out_valid <= fire || (r_out_valid && i_out_stall);
        end
        if (fire) begin
            r_tx_valid <= n_tx_valid;
            r_tx_byte  <= n_tx_byte;
            r_changed  <= n_changed;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_tx_valid     = r_tx_valid;
    assign o_tx_byte      = r_tx_byte;
    assign o_leds_changed = r_changed;
    assign o_led_state    = r_led;

    assign enter_first = fire && (n_state == ST_FIRST) && (r_state != ST_FIRST);

    // an LED write never sends a byte
    `KBL_ASSERT_NOW(a_led_no_tx, i_clk, i_rst_n, o_out_valid && o_leds_changed, !o_tx_valid)
    // silent results carry a zero byte
    `KBL_ASSERT_NOW(a_idle_byte_zero, i_clk, i_rst_n, o_out_valid && !o_tx_valid, o_tx_byte == '0)
    // input side only stalls behind a full, stalled output register
    `KBL_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_out_valid && i_out_stall)
    // entering the two-byte exchange always sends the first byte
    `KBL_ASSERT_NEXT(a_first_sent, i_clk, i_rst_n, enter_first, o_out_valid && o_tx_valid)

endmodule

`default_nettype wire

// File: tb/sv/tb_keyboard_link_protocol_engine.sv
// Self-checking testbench for keyboard_link_protocol_engine: handshake, commands,
// two-byte exchanges, mouse accumulation, ID register and backpressure.
// Depends on kbl_pkg and the RTL of the block; predicts every result in-line.
`default_nettype none

module tb_keyboard_link_protocol_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] C_NACK = 8'h30;
    localparam logic [7:0] C_SACK = 8'h31;
    localparam logic [7:0] C_MACK = 8'h32;
    localparam logic [7:0] C_SMAK = 8'h33;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int REPORT_MAX     = 63;
    localparam int REPORT_MIN     = -64;
    localparam int RESET_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 100;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic signed [kbl_pkg::DELTA_W-1:0]   t_delta;
    typedef logic signed [kbl_pkg::ACC_WIDTH-1:0] t_acc;
    typedef logic        [kbl_pkg::KB_ID_W-1:0]   t_kb_id;

    typedef enum logic [2:0] {
        LINK_PRE         = 3'd0,
        LINK_GOT_HRST    = 3'd1,
        LINK_GOT_RAK1    = 3'd2,
        LINK_READY       = 3'd3,
        LINK_FIRST_SENT  = 3'd4,
        LINK_SECOND_SENT = 3'd5
    } t_link_state;

    typedef struct {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic [7:0] key_code;
        logic       key_pressed;
        t_delta     delta_x;
        t_delta     delta_y;
    } t_link_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       leds_changed;
        logic [2:0] led_state;
    } t_link_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_kb_id     i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_op = '0;
    logic [7:0] i_rx_byte = '0;
    logic [7:0] i_key_code = '0;
    logic       i_key_pressed = 1'b0;
    t_delta     i_delta_x = '0;
    t_delta     i_delta_y = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_leds_changed;
    logic [2:0] o_led_state;

    // predicted link state
    t_link_state link_st;
    logic [2:0]  led_bits;
    logic        scan_on;
    logic        mouse_on;
    logic [7:0]  second_byte;
    t_acc        acc_x;
    t_acc        acc_y;
    t_kb_id      keyboard_id;

    t_link_result pending_results[$];

    bit send_gaps = 1'b0;
    bit recv_gaps = 1'b0;
    bit long_hold_req = 1'b0;
    int fail_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int link_errors = 0;
    int key_reports = 0;
    int mouse_reports = 0;
    int led_changes = 0;
    int long_holds = 0;
    int quiet_cycles = 0;

    keyboard_link_protocol_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_rx_byte      (i_rx_byte),
        .i_key_code     (i_key_code),
        .i_key_pressed  (i_key_pressed),
        .i_delta_x      (i_delta_x),
        .i_delta_y      (i_delta_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_leds_changed (o_leds_changed),
        .o_led_state    (o_led_state)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void report_failure(string msg);
        if (fail_count < 10) $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endfunction

    function automatic t_acc add_saturating(t_acc acc, t_delta d);
        longint sum;
        longint top;
        top = (longint'(1) << (kbl_pkg::ACC_WIDTH - 1)) - 1;
        sum = longint'(acc) + longint'(d);
        if (sum > top) sum = top;
        else if (sum < -top - 1) sum = -top - 1;
        return t_acc'(sum);
    endfunction

    function automatic logic [7:0] clamp_report(t_acc v);
        int c;
        c = int'(v);
        if (c > REPORT_MAX) c = REPORT_MAX;
        else if (c < REPORT_MIN) c = REPORT_MIN;
        return {1'b0, c[6:0]};
    endfunction

    // first byte of a mouse report; the y byte waits for BACK
    function automatic logic [7:0] take_mouse_report();
        logic [7:0] bx;
        bx = clamp_report(acc_x);
        second_byte = clamp_report(acc_y);
        acc_x = '0;
        acc_y = '0;
        link_st = LINK_FIRST_SENT;
        mouse_reports++;
        return bx;
    endfunction

    function automatic bit apply_mode(logic [7:0] b);
        case (b)
            C_NACK: {scan_on, mouse_on} = 2'b00;
            C_SACK: {scan_on, mouse_on} = 2'b10;
            C_MACK: {scan_on, mouse_on} = 2'b01;
            C_SMAK: {scan_on, mouse_on} = 2'b11;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic t_link_result predict_link_step(t_link_item it);
        t_link_result r;
        logic [7:0]   b;
        logic [3:0]   hi;
        bit           ok;
        r = '0;
        b = it.rx_byte;
        ok = 1'b1;
        case (it.op)
            kbl_pkg::OP_HOST: begin
                if (b == kbl_pkg::C_HRST) begin
                    link_st = LINK_GOT_HRST;
                    {r.tx_valid, r.tx_byte} = {1'b1, kbl_pkg::C_HRST};
                end else begin
                    case (link_st)
                        LINK_GOT_HRST: begin
                            ok = (b == kbl_pkg::C_RAK1);
                            if (ok) begin
                                link_st = LINK_GOT_RAK1;
                                {r.tx_valid, r.tx_byte} = {1'b1, kbl_pkg::C_RAK1};
                            end
                        end
                        LINK_GOT_RAK1: begin
                            ok = (b == kbl_pkg::C_RAK2);
                            if (ok) begin
                                link_st = LINK_READY;
                                {r.tx_valid, r.tx_byte} = {1'b1, kbl_pkg::C_RAK2};
                            end
                        end
                        LINK_READY: begin
                            if (b == kbl_pkg::C_PRST) begin
                                link_st = LINK_PRE;
                                {r.tx_valid, r.tx_byte} = {1'b1, kbl_pkg::C_HRST};
                            end else if (b == kbl_pkg::C_RQID) begin
                                {r.tx_valid, r.tx_byte} =
                                    {1'b1, kbl_pkg::C_KBID_HI, keyboard_id};
                            end else if (b == kbl_pkg::C_RQMP) begin
                                {r.tx_valid, r.tx_byte} = {1'b1, take_mouse_report()};
                            end else if (b <= kbl_pkg::C_LED_MAX) begin
                                if (b[2:0] != led_bits) begin
                                    led_bits = b[2:0];
                                    r.leds_changed = 1'b1;
                                    led_changes++;
                                end
                            end else if (b[7:4] == kbl_pkg::C_RQPD_HI) begin
                                {r.tx_valid, r.tx_byte} = {1'b1, kbl_pkg::C_PDAT};
                            end else begin
                                ok = apply_mode(b);
                            end
                        end
                        LINK_FIRST_SENT: begin
                            ok = (b == kbl_pkg::C_BACK);
                            if (ok) begin
                                link_st = LINK_SECOND_SENT;
                                {r.tx_valid, r.tx_byte} = {1'b1, second_byte};
                            end
                        end
                        LINK_SECOND_SENT: begin
                            ok = apply_mode(b);
                            if (ok) link_st = LINK_READY;
                        end
                        default: ok = 1'b0;
                    endcase
                    // protocol error: answer HRST and drop back to pre-reset
                    if (!ok) begin
                        link_st = LINK_PRE;
                        {r.tx_valid, r.tx_byte} = {1'b1, kbl_pkg::C_HRST};
                        link_errors++;
                    end
                end
            end
            kbl_pkg::OP_KEY: begin
                if (scan_on && link_st == LINK_READY) begin
                    hi = it.key_pressed ? kbl_pkg::C_KDDA_HI : kbl_pkg::C_KUDA_HI;
                    second_byte = {hi, it.key_code[3:0]};
                    link_st = LINK_FIRST_SENT;
                    {r.tx_valid, r.tx_byte} = {1'b1, hi, it.key_code[7:4]};
                    key_reports++;
                end
            end
            kbl_pkg::OP_MOUSE: begin
                acc_x = add_saturating(acc_x, it.delta_x);
                acc_y = add_saturating(acc_y, it.delta_y);
                if (mouse_on && link_st == LINK_READY)
                    {r.tx_valid, r.tx_byte} = {1'b1, take_mouse_report()};
            end
            default: ;
        endcase
        r.led_state = led_bits;
        return r;
    endfunction

    function automatic t_link_item random_link_item();
        t_link_item it;
        it.op = 2'($urandom_range(0, 3));
        it.rx_byte = 8'($urandom_range(0, 255));
        it.key_code = 8'($urandom_range(0, 255));
        it.key_pressed = 1'($urandom_range(0, 1));
        it.delta_x = t_delta'($urandom_range(0, (1 << kbl_pkg::DELTA_W) - 1));
        it.delta_y = t_delta'($urandom_range(0, (1 << kbl_pkg::DELTA_W) - 1));
        return it;
    endfunction

    function automatic t_link_item host_item(logic [7:0] b);
        t_link_item it;
        it = random_link_item();
        it.op = kbl_pkg::OP_HOST;
        it.rx_byte = b;
        return it;
    endfunction

    function automatic t_link_item key_item(logic [7:0] code, logic pressed);
        t_link_item it;
        it = random_link_item();
        it.op = kbl_pkg::OP_KEY;
        it.key_code = code;
        it.key_pressed = pressed;
        return it;
    endfunction

    function automatic t_link_item mouse_item(t_delta dx, t_delta dy);
        t_link_item it;
        it = random_link_item();
        it.op = kbl_pkg::OP_MOUSE;
        it.delta_x = dx;
        it.delta_y = dy;
        return it;
    endfunction

    // mostly well-formed traffic for the current link state, some noise
    function automatic t_link_item next_random_item();
        t_link_item it;
        int pick;
        it = random_link_item();
        pick = $urandom_range(0, 99);
        if (pick < 8) return it;
        it.op = kbl_pkg::OP_HOST;
        pick = $urandom_range(0, 99);
        case (link_st)
            LINK_GOT_HRST: if (pick < 85) it.rx_byte = kbl_pkg::C_RAK1;
            LINK_GOT_RAK1: if (pick < 85) it.rx_byte = kbl_pkg::C_RAK2;
            LINK_READY: begin
                if (pick < 14) it.rx_byte = 8'($urandom_range(0, kbl_pkg::C_LED_MAX));
                else if (pick < 21) it.rx_byte = kbl_pkg::C_RQID;
                else if (pick < 30) it.rx_byte = kbl_pkg::C_RQMP;
                else if (pick < 36)
                    it.rx_byte = {kbl_pkg::C_RQPD_HI, 4'($urandom_range(0, 15))};
                else if (pick < 48) it.rx_byte = C_NACK + 8'($urandom_range(0, 3));
                else if (pick < 70) it.op = kbl_pkg::OP_KEY;
                else if (pick < 94) it.op = kbl_pkg::OP_MOUSE;
                else if (pick < 96) it.rx_byte = kbl_pkg::C_PRST;
            end
            LINK_FIRST_SENT: begin
                if (pick < 75) it.rx_byte = kbl_pkg::C_BACK;
                else if (pick < 85) it.op = kbl_pkg::OP_KEY;
                else if (pick < 95) it.op = kbl_pkg::OP_MOUSE;
            end
            LINK_SECOND_SENT: if (pick < 85) it.rx_byte = C_NACK + 8'($urandom_range(0, 3));
            default: if (pick < 80) it.rx_byte = kbl_pkg::C_HRST;
        endcase
        // keep most movements small so reports stay in range
        if (it.op == kbl_pkg::OP_MOUSE && $urandom_range(0, 9) < 7) begin
            it.delta_x = t_delta'(int'($urandom_range(0, 160)) - 80);
            it.delta_y = t_delta'(int'($urandom_range(0, 160)) - 80);
        end
        return it;
    endfunction

    task automatic send_item(input t_link_item it);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= it.op;
        i_rx_byte     <= it.rx_byte;
        i_key_code    <= it.key_code;
        i_key_pressed <= it.key_pressed;
        i_delta_x     <= it.delta_x;
        i_delta_y     <= it.delta_y;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_link_step(it));
        items_sent++;
    endtask

    task automatic wait_link_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_keyboard_id(input t_kb_id id);
        wait_link_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= id;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        keyboard_id = id;
        cfg_writes++;
    endtask

    task automatic bring_link_up();
        send_item(host_item(kbl_pkg::C_HRST));
        send_item(host_item(kbl_pkg::C_RAK1));
        send_item(host_item(kbl_pkg::C_RAK2));
    endtask

    task automatic test_link_handshake();
        send_item(host_item(8'h55));
        send_item(key_item(8'h5A, 1'b1));
        send_item(host_item(kbl_pkg::C_HRST));
        send_item(host_item(8'h12));
        send_item(host_item(kbl_pkg::C_HRST));
        send_item(host_item(kbl_pkg::C_RAK1));
        send_item(host_item(kbl_pkg::C_RAK1));
        bring_link_up();
    endtask

    task automatic test_host_commands();
        t_link_item it;
        send_item(host_item(kbl_pkg::C_LED_MAX));
        send_item(host_item(kbl_pkg::C_LED_MAX));
        send_item(host_item(8'h00));
        send_item(host_item(kbl_pkg::C_RQID));
        send_item(host_item({kbl_pkg::C_RQPD_HI, 4'hF}));
        it = random_link_item();
        it.op = OP_UNUSED;
        send_item(it);
        send_item(key_item(8'hFF, 1'b1));
    endtask

    task automatic test_two_byte_exchanges();
        send_item(host_item(C_SMAK));
        send_item(key_item(8'hFF, 1'b1));
        send_item(key_item(8'h3C, 1'b0));
        send_item(mouse_item(t_delta'(5), t_delta'(-3)));
        send_item(host_item(kbl_pkg::C_BACK));
        send_item(host_item(C_SMAK));
        send_item(mouse_item(t_delta'(2047), t_delta'(-2048)));
        send_item(host_item(kbl_pkg::C_BACK));
        send_item(host_item(C_NACK));
        send_item(host_item(kbl_pkg::C_RQMP));
        send_item(host_item(kbl_pkg::C_BACK));
        send_item(host_item(C_SACK));
        send_item(key_item(8'h00, 1'b0));
        send_item(host_item(kbl_pkg::C_BACK));
        send_item(host_item(C_MACK));
        // BACK with no exchange open is a protocol error
        send_item(host_item(kbl_pkg::C_BACK));
        bring_link_up();
        send_item(host_item(kbl_pkg::C_PRST));
    endtask

    task automatic test_keyboard_id();
        write_keyboard_id('1);
        bring_link_up();
        send_item(host_item(kbl_pkg::C_RQID));
        write_keyboard_id('0);
        send_item(host_item(kbl_pkg::C_RQID));
        write_keyboard_id(t_kb_id'($urandom_range(0, 63)));
        send_item(host_item(kbl_pkg::C_RQID));
    endtask

    // push both accumulators into saturation with reports off, then read out
    task automatic test_accumulator_saturation();
        bring_link_up();
        send_item(host_item(C_NACK));
        repeat (40) send_item(mouse_item(t_delta'($urandom_range(1500, 2047)),
                                         t_delta'(-int'($urandom_range(1500, 2048)))));
        send_item(host_item(kbl_pkg::C_RQMP));
        send_item(host_item(kbl_pkg::C_BACK));
        send_item(host_item(C_NACK));
        repeat (40) send_item(mouse_item(t_delta'(-int'($urandom_range(1500, 2048))),
                                         t_delta'($urandom_range(1500, 2047))));
        send_item(host_item(C_MACK));
        send_item(mouse_item(t_delta'(-2048), t_delta'(2047)));
        send_item(host_item(kbl_pkg::C_BACK));
        send_item(host_item(C_NACK));
    endtask

    task automatic test_backpressure();
        bit saved;
        saved = send_gaps;
        send_gaps = 1'b0;
        long_hold_req = 1'b1;
        repeat (40) send_item(next_random_item());
        send_gaps = saved;
    endtask

    task automatic test_random_traffic(input int count, input bit gaps);
        send_gaps = gaps;
        recv_gaps = gaps;
        for (int seg = 0; seg < 4; seg++) begin
            write_keyboard_id(t_kb_id'($urandom_range(0, 63)));
            repeat (count / 4) send_item(next_random_item());
        end
    endtask

    // receiver: random stall bursts plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                long_holds++;
            end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_link_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_failure($sformatf("result with no item pending: tx %0b/%02h leds %0h",
                                         o_tx_valid, o_tx_byte, o_led_state));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_tx_valid !== want.tx_valid)
                    report_failure($sformatf("tx_valid expected %0b got %0b",
                                             want.tx_valid, o_tx_valid));
                if (o_tx_byte !== want.tx_byte)
                    report_failure($sformatf("tx_byte expected %02h got %02h",
                                             want.tx_byte, o_tx_byte));
                if (o_leds_changed !== want.leds_changed)
                    report_failure($sformatf("leds_changed expected %0b got %0b",
                                             want.leds_changed, o_leds_changed));
                if (o_led_state !== want.led_state)
                    report_failure($sformatf("led_state expected %0h got %0h",
                                             want.led_state, o_led_state));
            end
        end
    end

    // end the run if no transfer happens on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles", $time, quiet_cycles);
                $display("FAIL keyboard_link_protocol_engine");
                $finish;
            end
        end
    end

    initial begin
        int guard;
        link_st = LINK_PRE;
        led_bits = '0;
        scan_on = 1'b0;
        mouse_on = 1'b0;
        second_byte = '0;
        acc_x = '0;
        acc_y = '0;
        keyboard_id = kbl_pkg::KB_ID_RESET;
        guard = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        test_link_handshake();
        test_host_commands();
        test_two_byte_exchanges();
        test_keyboard_id();
        test_accumulator_saturation();
        test_backpressure();
        test_random_traffic(880, 1'b1);
        test_random_traffic(200, 1'b0);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_failure($sformatf("%0d results never arrived", pending_results.size()));

        $display("Run: %0d items, %0d results checked, %0d ID writes, %0d long receiver holds",
                 items_sent, results_checked, cfg_writes, long_holds);
        $display("Link: %0d protocol errors, %0d key reports, %0d mouse reports, %0d LED changes",
                 link_errors, key_reports, mouse_reports, led_changes);
        if (fail_count == 0) begin
            $display("PASS keyboard_link_protocol_engine");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAIL keyboard_link_protocol_engine");
        end
        $finish;
    end

endmodule

`default_nettype wire
